// ----- rtl/ecf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echelon form checker package
// Shared payload types, verdict and reason codes, and register indexes.
// ----------------------------------------------------------------------------
package ecf_pkg;

    // Width that holds any clamped count or position plus one (maxima up to 16).
    localparam int CNT_W = 5;

    typedef enum logic [1:0] {
        CFG_REDUCED_MODE = 2'd0,
        CFG_ROW_COUNT    = 2'd1,
        CFG_COLUMN_COUNT = 2'd2
    } ecf_cfg_index_t;

    localparam logic [2:0] ROW_COUNT_RESET    = 3'd4;
    localparam logic [2:0] COLUMN_COUNT_RESET = 3'd6;

    localparam logic [1:0] VERDICT_PASSED       = 2'd0;
    localparam logic [1:0] VERDICT_FAILED       = 2'd1;
    localparam logic [1:0] VERDICT_INCONCLUSIVE = 2'd2;

    localparam logic [2:0] REASON_NONE            = 3'd0;
    localparam logic [2:0] REASON_AFTER_ZERO_ROW  = 3'd1;
    localparam logic [2:0] REASON_NOT_RIGHT       = 3'd2;
    localparam logic [2:0] REASON_LEADING_NOT_ONE = 3'd3;
    localparam logic [2:0] REASON_NONZERO_ABOVE   = 3'd4;
    localparam logic [2:0] REASON_INEXACT         = 3'd5;

    typedef struct packed {
        logic signed [31:0] numerator;
        logic        [31:0] denominator;
        logic               cell_inexact;
    } ecf_cell_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] reason;
    } ecf_result_t;

    // Handshake between the check core and the two register stages.
    typedef struct packed {
        logic        fire;
        logic        emit;
        ecf_result_t result;
    } ecf_status_t;

endpackage

// ----- rtl/ecf_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echelon form checker input stage
// Holds one accepted cell until the check core consumes it.
// ----------------------------------------------------------------------------
module ecf_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cell_valid,
    output logic              cell_ready,
    input  ecf_pkg::ecf_cell_t cell_data,
    input  ecf_pkg::ecf_status_t status,
    output logic              held_valid,
    output ecf_pkg::ecf_cell_t held_cell
);
    import ecf_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ecf_cell_t cell_reg;

    // A new cell may enter while the stage is empty or when the held one leaves in this cycle.
    assign cell_ready = !valid_reg || status.fire;
    assign valid_next = cell_valid ? 1'b1 : (status.fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cell_ready)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_valid && cell_ready)
        begin
            cell_reg <= cell_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_cell  = cell_reg;

endmodule

// ----- rtl/ecf_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echelon form checker core
// Walks the matrix one cell at a time and keeps the first failure found.
// ----------------------------------------------------------------------------
module ecf_core #(
    parameter int MAX_ROWS    = 4,
    parameter int MAX_COLUMNS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                held_valid,
    input  ecf_pkg::ecf_cell_t  held_cell,
    input  logic                slot_free,
    input  logic                reduced_mode,
    input  logic [2:0]          row_count,
    input  logic [2:0]          column_count,
    output ecf_pkg::ecf_status_t status
);
    import ecf_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LPW = $clog2(MAX_COLUMNS + 1);

    logic [RW-1:0]          row_pos_reg, row_pos_next;
    logic [CW-1:0]          col_pos_reg, col_pos_next;
    logic                   pivot_found_reg, pivot_found_next;
    logic                   zero_row_reg, zero_row_next;
    logic [LPW-1:0]         least_pivot_reg, least_pivot_next;
    logic [MAX_COLUMNS-1:0] above_reg, above_next;
    logic [MAX_COLUMNS-1:0] pending_reg, pending_next;
    logic [2:0]             failure_reg, failure_next;
    logic                   inexact_reg, inexact_next;

    logic [CNT_W-1:0] rows_used;
    logic [CNT_W-1:0] cols_used;
    logic             nonzero;
    logic             leading;
    logic             leading_one;
    logic [2:0]       fail_code;
    logic             row_end;
    logic             matrix_end;
    logic             fire;
    logic             inexact_all;

    always_comb
    begin
        if (row_count == 3'd0)
            rows_used = CNT_W'(1);
        else if (CNT_W'(row_count) > CNT_W'(MAX_ROWS))
            rows_used = CNT_W'(MAX_ROWS);
        else
            rows_used = CNT_W'(row_count);

        if (column_count == 3'd0)
            cols_used = CNT_W'(1);
        else if (CNT_W'(column_count) > CNT_W'(MAX_COLUMNS))
            cols_used = CNT_W'(MAX_COLUMNS);
        else
            cols_used = CNT_W'(column_count);
    end

    assign nonzero     = (held_cell.numerator != 32'sd0);
    assign leading     = nonzero && !pivot_found_reg;
    // The sign bit is checked first, so a negative numerator never matches.
    assign leading_one = !held_cell.numerator[31]
                         && ($unsigned(held_cell.numerator) == held_cell.denominator);

    always_comb
    begin
        if (zero_row_reg)
            fail_code = REASON_AFTER_ZERO_ROW;
        else if (LPW'(col_pos_reg) < least_pivot_reg)
            fail_code = REASON_NOT_RIGHT;
        else if (reduced_mode && !leading_one)
            fail_code = REASON_LEADING_NOT_ONE;
        else if (reduced_mode && above_reg[col_pos_reg])
            fail_code = REASON_NONZERO_ABOVE;
        else
            fail_code = REASON_NONE;
    end

    assign row_end    = (CNT_W'(col_pos_reg) + CNT_W'(1)) >= cols_used;
    assign matrix_end = row_end && ((CNT_W'(row_pos_reg) + CNT_W'(1)) >= rows_used);
    assign fire       = held_valid && (!matrix_end || slot_free);
    assign inexact_all = inexact_reg || held_cell.cell_inexact;

    always_comb
    begin
        row_pos_next     = row_pos_reg;
        col_pos_next     = col_pos_reg;
        pivot_found_next = pivot_found_reg || nonzero;
        zero_row_next    = zero_row_reg;
        least_pivot_next = leading ? (LPW'(col_pos_reg) + LPW'(1)) : least_pivot_reg;
        above_next       = above_reg;
        pending_next     = pending_reg | (nonzero ? (MAX_COLUMNS'(1) << col_pos_reg)
                                                  : '0);
        failure_next     = (leading && (failure_reg == REASON_NONE)) ? fail_code
                                                                     : failure_reg;
        inexact_next     = inexact_all;

        if (!row_end)
        begin
            col_pos_next = col_pos_reg + 1'b1;
        end
        else if (!matrix_end)
        begin
            // Nonzeros of the finished row now count as lying above later rows.
            above_next       = above_reg | pending_next;
            pending_next     = '0;
            zero_row_next    = zero_row_reg || !pivot_found_next;
            pivot_found_next = 1'b0;
            col_pos_next     = '0;
            row_pos_next     = row_pos_reg + 1'b1;
        end
        else
        begin
            row_pos_next     = '0;
            col_pos_next     = '0;
            pivot_found_next = 1'b0;
            zero_row_next    = 1'b0;
            least_pivot_next = '0;
            above_next       = '0;
            pending_next     = '0;
            failure_next     = REASON_NONE;
            inexact_next     = 1'b0;
        end
    end

    always_comb
    begin
        status.fire = fire;
        status.emit = fire && matrix_end;
        if (inexact_all)
        begin
            status.result.verdict = VERDICT_INCONCLUSIVE;
            status.result.reason  = REASON_INEXACT;
        end
        else if (failure_next != REASON_NONE && !matrix_end)
        begin
            status.result.verdict = VERDICT_FAILED;
            status.result.reason  = failure_next;
        end
        else if (leading && (failure_reg == REASON_NONE) && (fail_code != REASON_NONE))
        begin
            status.result.verdict = VERDICT_FAILED;
            status.result.reason  = fail_code;
        end
        else if (failure_reg != REASON_NONE)
        begin
            status.result.verdict = VERDICT_FAILED;
            status.result.reason  = failure_reg;
        end
        else
        begin
            status.result.verdict = VERDICT_PASSED;
            status.result.reason  = REASON_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            pivot_found_reg <= 1'b0;
            zero_row_reg    <= 1'b0;
            least_pivot_reg <= '0;
            above_reg       <= '0;
            pending_reg     <= '0;
            failure_reg     <= REASON_NONE;
            inexact_reg     <= 1'b0;
        end
        else if (fire)
        begin
            row_pos_reg     <= row_pos_next;
            col_pos_reg     <= col_pos_next;
            pivot_found_reg <= pivot_found_next;
            zero_row_reg    <= zero_row_next;
            least_pivot_reg <= least_pivot_next;
            above_reg       <= above_next;
            pending_reg     <= pending_next;
            failure_reg     <= failure_next;
            inexact_reg     <= inexact_next;
        end
    end

endmodule

// ----- rtl/ecf_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echelon form checker output stage
// Holds the verdict of a finished matrix until the receiver takes it.
// ----------------------------------------------------------------------------
module ecf_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecf_pkg::ecf_status_t status,
    output logic                 slot_free,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ecf_pkg::ecf_result_t result
);
    import ecf_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ecf_result_t result_reg;

    assign slot_free  = !valid_reg || result_ready;
    assign valid_next = status.emit ? 1'b1 : (result_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.emit)
        begin
            result_reg <= status.result;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/echelon_form_checker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echelon form checker
// Checks a streamed matrix for row echelon or reduced row echelon form.
// ----------------------------------------------------------------------------
// Usage:
//   Cells arrive on the cell channel in row-major order, one per transfer.
//   After the last cell of a matrix (row_count by column_count, clamped to
//   the maxima) one verdict with a reason leaves on the result channel; all
//   other cells give no result. The next matrix starts with the next cell.
//   The configuration channel writes reduced_mode, row_count and
//   column_count by index; it is always ready and should be used only while
//   no matrix is in progress and no cell or result is still in flight.
//   Throughput is one cell per cycle while cell_ready stays high. A cell is
//   taken into the input register at its transfer and is checked by the core
//   from there against a handful of small state registers; the verdict is
//   loaded into the result register at the edge at which the last cell leaves
//   the input register.
//   While the receiver stalls, cells keep flowing until the last cell of the
//   next matrix needs the occupied result register; then cell_ready drops.
//   Reset clears all matrix progress and both stages and restores the
//   register defaults: echelon mode, four rows, six columns.
// ----------------------------------------------------------------------------
module echelon_form_checker_top #(
    parameter int MAX_ROWS    = 4,
    parameter int MAX_COLUMNS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    output logic                 cell_ready,
    input  ecf_pkg::ecf_cell_t   cell_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ecf_pkg::ecf_result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [2:0]           cfg_data
);
    import ecf_pkg::*;

    logic        reduced_mode_reg;
    logic [2:0]  row_count_reg;
    logic [2:0]  column_count_reg;
    logic        held_valid;
    ecf_cell_t   held_cell;
    logic        slot_free;
    ecf_status_t status;

    assign cfg_ready = 1'b1;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduced_mode_reg <= 1'b0;
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REDUCED_MODE: reduced_mode_reg <= cfg_data[0];
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    ecf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .status     (status),
        .held_valid (held_valid),
        .held_cell  (held_cell)
    );

    ecf_core #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .held_valid   (held_valid),
        .held_cell    (held_cell),
        .slot_free    (slot_free),
        .reduced_mode (reduced_mode_reg),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .status       (status)
    );

    ecf_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- rtl/ecf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echelon form checker port checks
// Watches the top-level ports for verdict consistency and flow control.
// ----------------------------------------------------------------------------
module ecf_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cell_valid,
    input logic                 cell_ready,
    input ecf_pkg::ecf_cell_t   cell_data,
    input logic                 result_valid,
    input logic                 result_ready,
    input ecf_pkg::ecf_result_t result,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);
    import ecf_pkg::*;

    // A stalled cell transfer must hold its payload.
    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_ready |=> cell_valid && $stable(cell_data))
        else $error("cell changed or dropped while stalled");

    // A stalled result must hold.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // Each verdict comes with a matching reason.
    a_reason_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result.verdict == VERDICT_PASSED) && (result.reason == REASON_NONE))
         || ((result.verdict == VERDICT_INCONCLUSIVE) && (result.reason == REASON_INEXACT))
         || ((result.verdict == VERDICT_FAILED)
             && ((result.reason == REASON_AFTER_ZERO_ROW)
              || (result.reason == REASON_NOT_RIGHT)
              || (result.reason == REASON_LEADING_NOT_ONE)
              || (result.reason == REASON_NONZERO_ABOVE))))
        else $error("verdict and reason disagree");

    // Cells are refused only while a finished verdict waits on the receiver.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_ready |-> result_valid && !result_ready)
        else $error("cell channel stalled without a result backlog");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transfer refused");

endmodule

bind echelon_form_checker_top ecf_checker u_ecf_checker (.*);

// ----- tb/sv/tb_echelon_form_checker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echelon form checker testbench
// Streams matrices into the cell channel and checks every verdict against a
// cycle-free model of the checker. A directed set of small matrices comes
// first. Random matrices follow, mostly in echelon or reduced form with a few
// corruptions, under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_echelon_form_checker_top;
    import ecf_pkg::*;

    localparam int MAX_ROWS          = 4;
    localparam int MAX_COLUMNS       = 6;
    localparam int CELLS_PER_SETTING = 160;
    localparam int QUIET_CYCLES      = 8;
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {CELL_ZERO, CELL_ONE, CELL_OTHER} cell_kind_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cell_valid   = 1'b0;
    logic        cell_ready;
    ecf_cell_t   cell_data    = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    ecf_result_t result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = CFG_REDUCED_MODE;
    logic [2:0]  cfg_data     = '0;

    echelon_form_checker_top #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ecf_cell_t   cells_pending[$];
    ecf_result_t verdicts_due[$];
    ecf_result_t verdict_head;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches    = 0;

    // Register copies and matrix progress of the checker model.
    logic       cfg_reduced;
    logic [2:0] cfg_rows;
    logic [2:0] cfg_cols;
    int         pos_row;
    int         pos_col;
    logic       row_has_pivot;
    logic       seen_zero_row;
    int         next_pivot_min;
    logic [5:0] above_mask;
    logic [5:0] row_mask;
    logic [2:0] first_fail;
    logic       saw_inexact;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int clamp_count(logic [2:0] value, int max_value);
        if (value == 3'd0)
            return 1;
        return (value > max_value) ? max_value : int'(value);
    endfunction

    task automatic clear_progress();
        pos_row        = 0;
        pos_col        = 0;
        row_has_pivot  = 1'b0;
        seen_zero_row  = 1'b0;
        next_pivot_min = 0;
        above_mask     = '0;
        row_mask       = '0;
        first_fail     = REASON_NONE;
        saw_inexact    = 1'b0;
    endtask

    task automatic predict_cell(input ecf_cell_t c);
        int          rows_eff;
        int          cols_eff;
        int          col;
        logic [5:0]  col_bit;
        logic [63:0] num_ext;
        logic [63:0] den_ext;
        logic [2:0]  fail_now;
        ecf_result_t verdict;
        rows_eff = clamp_count(cfg_rows, MAX_ROWS);
        cols_eff = clamp_count(cfg_cols, MAX_COLUMNS);
        col = (pos_col >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : pos_col;
        col_bit = 6'b1 << col;
        if (c.cell_inexact)
            saw_inexact = 1'b1;

        if (c.numerator != 0 && !row_has_pivot)
        begin
            row_has_pivot = 1'b1;
            num_ext  = {{32{c.numerator[31]}}, c.numerator};
            den_ext  = {32'd0, c.denominator};
            fail_now = REASON_NONE;
            if (seen_zero_row)
                fail_now = REASON_AFTER_ZERO_ROW;
            else if (col < next_pivot_min)
                fail_now = REASON_NOT_RIGHT;
            else if (cfg_reduced && num_ext != den_ext)
                fail_now = REASON_LEADING_NOT_ONE;
            else if (cfg_reduced && (above_mask & col_bit) != '0)
                fail_now = REASON_NONZERO_ABOVE;
            if (first_fail == REASON_NONE)
                first_fail = fail_now;
            next_pivot_min = col + 1;
        end

        // Nonzeros of the current row count as above only once the row is done.
        if (c.numerator != 0)
            row_mask |= col_bit;

        if (pos_col + 1 < cols_eff)
        begin
            pos_col++;
            return;
        end

        above_mask |= row_mask;
        row_mask = '0;
        if (!row_has_pivot)
            seen_zero_row = 1'b1;
        row_has_pivot = 1'b0;
        pos_col = 0;

        if (pos_row + 1 < rows_eff)
        begin
            pos_row++;
            return;
        end

        if (saw_inexact)
        begin
            verdict.verdict = VERDICT_INCONCLUSIVE;
            verdict.reason  = REASON_INEXACT;
        end
        else if (first_fail != REASON_NONE)
        begin
            verdict.verdict = VERDICT_FAILED;
            verdict.reason  = first_fail;
        end
        else
        begin
            verdict.verdict = VERDICT_PASSED;
            verdict.reason  = REASON_NONE;
        end
        verdicts_due.push_back(verdict);
        clear_progress();
    endtask

    // Cell driver: holds each cell until its transfer, then feeds the model.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cell_valid && cell_ready)
            begin
                predict_cell(cell_data);
                void'(cells_pending.pop_front());
            end
            if (!cell_valid || cell_ready)
            begin
                if (cells_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cell_valid <= 1'b1;
                    cell_data  <= cells_pending[0];
                end
                else
                begin
                    cell_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with a randomly stalling receiver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result transfer with no verdict pending: verdict %0d reason %0d",
                           result.verdict, result.reason);
                    mismatches++;
                end
                else
                begin
                    verdict_head = verdicts_due.pop_front();
                    if (result.verdict !== verdict_head.verdict)
                    begin
                        $error("verdict: expected %0d, actual %0d",
                               verdict_head.verdict, result.verdict);
                        mismatches++;
                    end
                    if (result.reason !== verdict_head.reason)
                    begin
                        $error("reason: expected %0d, actual %0d",
                               verdict_head.reason, result.reason);
                        mismatches++;
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [2:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_REDUCED_MODE: cfg_reduced = data[0];
            CFG_ROW_COUNT:    cfg_rows    = data;
            CFG_COLUMN_COUNT: cfg_cols    = data;
            default: ;
        endcase
    endtask

    // Waits until every cell has gone in and every verdict has come out.
    task automatic wait_quiet();
        while (cells_pending.size() != 0 || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic ecf_cell_t cell_of(logic [31:0] num, logic [31:0] den, logic inexact);
        ecf_cell_t c;
        c.numerator    = num;
        c.denominator  = den;
        c.cell_inexact = inexact;
        return c;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return $urandom_range(15);
            default: return $urandom();
        endcase
    endfunction

    function automatic ecf_cell_t make_cell(cell_kind_t kind);
        ecf_cell_t  c;
        logic [31:0] d;
        c.cell_inexact = 1'b0;
        case (kind)
            CELL_ZERO:
            begin
                c.numerator   = '0;
                c.denominator = pick_word();
            end
            CELL_ONE:
            begin
                d = $urandom_range(1) ? 32'd1 : ($urandom() & 32'h7FFF_FFFF);
                if (d == 32'd0)
                    d = 32'd1;
                c.numerator   = d;
                c.denominator = d;
            end
            default:
            begin
                do
                    c.numerator = pick_word();
                while (c.numerator == 0);
                c.denominator = pick_word();
            end
        endcase
        return c;
    endfunction

    // Builds one matrix for the current setting and queues it in row-major order.
    task automatic queue_matrix(input int rows, input int cols);
        ecf_cell_t grid [MAX_ROWS][MAX_COLUMNS];
        int        piv [MAX_ROWS];
        int        npiv;
        int        limit;
        int        prev;
        int        r;
        int        c;
        int        k;
        logic      rref_like;
        logic      pivot_col;
        limit = (rows < cols) ? rows : cols;
        npiv  = $urandom_range(1) ? limit : $urandom_range(limit);
        rref_like = cfg_reduced ? ($urandom_range(99) < 75) : ($urandom_range(99) < 30);
        prev = -1;
        for (r = 0; r < npiv; r++)
        begin
            piv[r] = $urandom_range(cols - (npiv - r), prev + 1);
            prev = piv[r];
        end

        for (r = 0; r < rows; r++)
        begin
            for (c = 0; c < cols; c++)
            begin
                if ($urandom_range(99) < 12)
                    grid[r][c] = make_cell(cell_kind_t'($urandom_range(2)));
                else if (r >= npiv || c < piv[r])
                    grid[r][c] = make_cell(CELL_ZERO);
                else if (c == piv[r])
                    grid[r][c] = make_cell((rref_like || $urandom_range(1)) ? CELL_ONE
                                                                              : CELL_OTHER);
                else
                begin
                    pivot_col = 1'b0;
                    for (k = r + 1; k < npiv; k++)
                        if (piv[k] == c)
                            pivot_col = 1'b1;
                    if ((rref_like && pivot_col) || $urandom_range(1))
                        grid[r][c] = make_cell(CELL_ZERO);
                    else
                        grid[r][c] = make_cell(CELL_OTHER);
                end
            end
        end

        if ($urandom_range(99) < 25)
            grid[$urandom_range(rows - 1)][$urandom_range(cols - 1)] =
                make_cell(cell_kind_t'($urandom_range(2)));
        if ($urandom_range(99) < 6)
            grid[$urandom_range(rows - 1)][$urandom_range(cols - 1)].cell_inexact = 1'b1;

        for (r = 0; r < rows; r++)
            for (c = 0; c < cols; c++)
                cells_pending.push_back(grid[r][c]);
    endtask

    initial
    begin
        logic       set_reduced [10];
        logic [2:0] set_rows    [10];
        logic [2:0] set_cols    [10];
        int         s;
        int         budget;
        int         rows_eff;
        int         cols_eff;

        set_reduced = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        set_rows    = '{3'd4, 3'd4, 3'd1, 3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4};
        set_cols    = '{3'd6, 3'd6, 3'd1, 3'd6, 3'd1, 3'd7, 3'd0, 3'd4, 3'd5, 3'd6};
        set_reduced[9] = 1'($urandom_range(1));
        set_rows[9]    = 3'($urandom_range(7));
        set_cols[9]    = 3'($urandom_range(7));

        cfg_reduced = 1'b0;
        cfg_rows    = ROW_COUNT_RESET;
        cfg_cols    = COLUMN_COUNT_RESET;
        clear_progress();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting on 2 by 2 matrices in reduced mode.
        send_idle_pct = 30;
        recv_idle_pct = 83;
        write_reg(CFG_REDUCED_MODE, 3'd1);
        write_reg(CFG_ROW_COUNT, 3'd2);
        write_reg(CFG_COLUMN_COUNT, 3'd2);
        // Nonzero row under a zero row, largest numerator.
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'hFFFF_FFFF, 1'b0));
        cells_pending.push_back(cell_of(32'h7FFF_FFFF, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        // Second pivot left of the first.
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        // Smallest numerator against an equal-looking denominator: not a one.
        cells_pending.push_back(cell_of(32'h8000_0000, 32'h8000_0000, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        // Nonzero entry above the second pivot.
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        // Zero cell with a zero denominator, then minus one over all ones.
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd0, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'hFFFF_FFFF, 1'b0));
        cells_pending.push_back(cell_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        // First row of a matrix, then registers change before the second row.
        cells_pending.push_back(cell_of(32'd1, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        wait_quiet();
        write_reg(CFG_COLUMN_COUNT, 3'd3);
        write_reg(CFG_REDUCED_MODE, 3'd0);
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(32'd0, 32'd1, 1'b0));
        cells_pending.push_back(cell_of(-32'sd5, 32'd3, 1'b0));
        wait_quiet();
        // An unused index changes nothing; then one inexact 1 by 1 matrix.
        write_reg(CFG_UNUSED_INDEX, 3'd5);
        write_reg(CFG_ROW_COUNT, 3'd1);
        write_reg(CFG_COLUMN_COUNT, 3'd1);
        cells_pending.push_back(cell_of(32'd7, 32'd7, 1'b1));
        wait_quiet();

        // Random matrices under each setting, idling pattern rotating.
        for (s = 0; s < 10; s++)
        begin
            case (s % 3)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 83;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_reg(CFG_REDUCED_MODE, {2'b00, set_reduced[s]});
            write_reg(CFG_ROW_COUNT, set_rows[s]);
            write_reg(CFG_COLUMN_COUNT, set_cols[s]);
            rows_eff = clamp_count(cfg_rows, MAX_ROWS);
            cols_eff = clamp_count(cfg_cols, MAX_COLUMNS);
            budget = CELLS_PER_SETTING;
            while (budget > 0)
            begin
                queue_matrix(rows_eff, cols_eff);
                budget -= rows_eff * cols_eff;
            end
            wait_quiet();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ecf_pkg.sv
rtl/ecf_in_stage.sv
rtl/ecf_core.sv
rtl/ecf_out_stage.sv
rtl/echelon_form_checker_top.sv
rtl/ecf_checker.sv
tb/sv/tb_echelon_form_checker_top.sv
